/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, reset disables the check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tdfp_pkg.sv */
// ----------------------------------------------------------------------------
// tdfp_pkg
// shared types, codes and constants of the tagged decimal field parser
// ----------------------------------------------------------------------------
package tdfp_pkg;

    localparam int BUFFER_DEPTH_DEF = 8;
    localparam int CHAR_W           = 8;
    localparam int TEXT_CHARS       = 7;
    localparam int TEXT_W           = TEXT_CHARS * CHAR_W;
    localparam int TAG_W            = 2;
    localparam int VAL_W            = 25;
    localparam int MAG_W            = 25;
    localparam int LIMIT_W          = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd50;
    localparam logic [MAG_W-1:0]   MAG_CAP     = 25'h1000000;

    // result tags
    localparam logic [TAG_W-1:0] TAG_VEL  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_RPM  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_GEAR = 2'd2;
    localparam logic [TAG_W-1:0] TAG_OVF  = 2'd3;

    // characters
    localparam logic [CHAR_W-1:0] CH_V     = 8'h56;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // register file
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_VELOCITY_LIMIT = 1'b0;

    typedef struct packed {
        logic wr;
        logic shift;
        logic clear;
    } store_ctrl_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } scan_res_t;

endpackage

/* hdl/tdfp_rx_if.sv */
// ----------------------------------------------------------------------------
// tdfp_rx_if
// received byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tdfp_rx_if
    import tdfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/tdfp_field_if.sv */
// ----------------------------------------------------------------------------
// tdfp_field_if
// parsed field channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tdfp_field_if
    import tdfp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [TAG_W-1:0]        field_tag;
    logic [TEXT_W-1:0]       field_text;
    logic signed [VAL_W-1:0] parsed_value;
    logic signed [VAL_W-1:0] limited_value;

    modport source (output valid, output field_tag, output field_text,
                    output parsed_value, output limited_value, input ready);
    modport sink   (input valid, input field_tag, input field_text,
                    input parsed_value, input limited_value, output ready);
endinterface

/* hdl/tdfp_store.sv */
// ----------------------------------------------------------------------------
// tdfp_store
// character shift store: appends bytes, drains one character a cycle
// ----------------------------------------------------------------------------
module tdfp_store
    import tdfp_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_ctrl_t       ctrl,
    input  logic [CHAR_W-1:0] wr_byte,
    output logic              full,
    output logic [CHAR_W-1:0] head,
    output logic [TEXT_W-1:0] text
);

    localparam int STORE_DEPTH = BUFFER_DEPTH - 1;
    localparam int CNT_W       = $clog2(BUFFER_DEPTH);
    localparam int SHOWN       = (STORE_DEPTH < TEXT_CHARS) ? STORE_DEPTH : TEXT_CHARS;

    logic [CHAR_W-1:0] char_reg  [STORE_DEPTH];
    logic [CHAR_W-1:0] char_next [STORE_DEPTH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    always_comb
    begin
        char_next = char_reg;
        cnt_next  = cnt_reg;
        priority if (ctrl.clear)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                char_next[i] = '0;
            end
            cnt_next = '0;
        end
        else if (ctrl.wr)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                if (cnt_reg == CNT_W'(i))
                begin
                    char_next[i] = wr_byte;
                end
            end
            cnt_next = cnt_reg + 1'b1;
        end
        else if (ctrl.shift)
        begin
            // move toward the head, zeros fill in behind
            for (int i = 0; i < STORE_DEPTH - 1; i++)
            begin
                char_next[i] = char_reg[i+1];
            end
            char_next[STORE_DEPTH-1] = '0;
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                char_reg[i] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            char_reg <= char_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign full = (cnt_reg == CNT_W'(STORE_DEPTH));
    assign head = char_reg[0];

    always_comb
    begin
        text = '0;
        for (int i = 0; i < SHOWN; i++)
        begin
            text[CHAR_W*i +: CHAR_W] = char_reg[i];
        end
    end

endmodule

/* hdl/tdfp_scan.sv */
// ----------------------------------------------------------------------------
// tdfp_scan
// digit-serial decimal accumulator, one character per step
// ----------------------------------------------------------------------------
module tdfp_scan
    import tdfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] ch,
    output scan_res_t         res
);

    localparam int PROD_W = MAG_W + 4;

    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] mag_next;
    logic             neg_reg;
    logic             neg_next;

    logic             is_digit;
    logic             is_blank;
    logic             is_sign;
    logic [3:0]       dval;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0] mag_acc;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign dval     = 4'(ch - CH_ZERO);

    // mag * 10 + digit, saturating at the cap
    assign prod    = (PROD_W'(mag_reg) << 3) + (PROD_W'(mag_reg) << 1) + PROD_W'(dval);
    assign mag_acc = (prod > PROD_W'(MAG_CAP)) ? MAG_CAP : prod[MAG_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        if (ctrl.start)
        begin
            phase_next = PH_BLANK;
            mag_next   = '0;
            neg_next   = 1'b0;
        end
        else if (ctrl.step)
        begin
            unique case (phase_reg)
                PH_BLANK:
                begin
                    if (is_blank)
                    begin
                        phase_next = PH_BLANK;
                    end
                    else if (is_sign)
                    begin
                        neg_next   = (ch == CH_MINUS);
                        phase_next = PH_DIGIT;
                    end
                    else if (is_digit)
                    begin
                        mag_next   = mag_acc;
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_DIGIT:
                begin
                    if (is_digit)
                    begin
                        mag_next = mag_acc;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                    phase_next = PH_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOP;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
        end
    end

    assign res.neg = neg_reg;
    assign res.mag = mag_reg;

endmodule

/* hdl/tdfp_apb.sv */
// ----------------------------------------------------------------------------
// tdfp_apb
// register port holding the velocity limit
// ----------------------------------------------------------------------------
module tdfp_apb
    import tdfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    velocity_limit
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               hit;

    assign pready = 1'b1;
    assign hit    = (paddr[REG_IDX_BIT] == REG_VELOCITY_LIMIT);

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign prdata         = hit ? APB_DATA_W'(limit_reg) : '0;
    assign velocity_limit = limit_reg;

endmodule

/* hdl/tagged_decimal_field_parser.sv */
// ----------------------------------------------------------------------------
// tagged_decimal_field_parser
// collects received bytes into a short text store and, on a terminator,
// emits the tagged field with its decimal value for velocity fields
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  rx       in   valid / ready      rx_byte
//  field    out  valid / ready      field_tag, field_text, parsed_value,
//                                   limited_value
//  apb      in   psel/penable/...   velocity_limit where paddr[2] is 0
//
//  an ordinary byte is written into the store; a byte that finds the store
//  full is dropped, the store is emptied and an overflow item goes out
//  a terminator snapshots the text, then the store drains one character a
//  cycle through the decimal accumulator, then sign and limit are applied
//  and the item moves into the output register
//  reset empties the store and sets the velocity limit to 50
//  a held output item stalls the block only when the next item is ready
//  to go out; ordinary bytes keep being taken meanwhile
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tagged_decimal_field_parser
    import tdfp_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tdfp_rx_if.sink               rx,
    tdfp_field_if.source          field,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int STORE_DEPTH = BUFFER_DEPTH - 1;
    localparam int CNT_W       = $clog2(BUFFER_DEPTH);
    localparam logic [CNT_W-1:0] WALK_LAST = CNT_W'(STORE_DEPTH - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        walk_reg, walk_next;

    // result being built
    logic [TAG_W-1:0]        pend_tag_reg, pend_tag_next;
    logic [TEXT_W-1:0]       pend_text_reg, pend_text_next;
    logic [VAL_W-1:0]        pend_parsed_reg, pend_parsed_next;
    logic [VAL_W-1:0]        pend_limited_reg, pend_limited_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]        out_tag_reg, out_tag_next;
    logic [TEXT_W-1:0]       out_text_reg, out_text_next;
    logic [VAL_W-1:0]        out_parsed_reg, out_parsed_next;
    logic [VAL_W-1:0]        out_limited_reg, out_limited_next;

    store_ctrl_t             st_ctrl;
    scan_ctrl_t              sc_ctrl;
    scan_res_t               sc_res;
    logic                    store_full;
    logic [CHAR_W-1:0]       store_head;
    logic [TEXT_W-1:0]       store_text;
    logic [LIMIT_W-1:0]      velocity_limit;

    logic                    accept;
    logic                    is_term;
    logic [TAG_W-1:0]        term_tag;
    logic [VAL_W-1:0]        signed_val;
    logic [VAL_W-1:0]        limit_ext;

    tdfp_apb u_apb
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .velocity_limit (velocity_limit)
    );

    tdfp_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (st_ctrl),
        .wr_byte (rx.rx_byte),
        .full    (store_full),
        .head    (store_head),
        .text    (store_text)
    );

    tdfp_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (sc_ctrl),
        .ch    (store_head),
        .res   (sc_res)
    );

    assign rx.ready = (state_reg == ST_IDLE);
    assign accept   = rx.valid && rx.ready;

    assign is_term  = (rx.rx_byte == CH_V) || (rx.rx_byte == CH_S) || (rx.rx_byte == CH_E);
    assign term_tag = (rx.rx_byte == CH_V) ? TAG_VEL :
                      (rx.rx_byte == CH_S) ? TAG_RPM : TAG_GEAR;

    // sign applied to the magnitude; the cap compares magnitudes so that
    // a saturated positive value still reads as positive
    assign signed_val = sc_res.neg ? VAL_W'(~sc_res.mag + 1'b1) : sc_res.mag;
    assign limit_ext  = VAL_W'(velocity_limit);

    always_comb
    begin
        state_next        = state_reg;
        walk_next         = walk_reg;
        pend_tag_next     = pend_tag_reg;
        pend_text_next    = pend_text_reg;
        pend_parsed_next  = pend_parsed_reg;
        pend_limited_next = pend_limited_reg;
        out_valid_next    = out_valid_reg;
        out_tag_next      = out_tag_reg;
        out_text_next     = out_text_reg;
        out_parsed_next   = out_parsed_reg;
        out_limited_next  = out_limited_reg;
        st_ctrl           = '0;
        sc_ctrl           = '0;

        if (field.valid && field.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_term)
                    begin
                        // snapshot text now, the walk drains the store
                        pend_tag_next  = term_tag;
                        pend_text_next = store_text;
                        sc_ctrl.start  = 1'b1;
                        walk_next      = '0;
                        state_next     = ST_WALK;
                    end
                    else if (!store_full)
                    begin
                        st_ctrl.wr = 1'b1;
                    end
                    else
                    begin
                        // overflow: drop the byte, empty the store
                        st_ctrl.clear     = 1'b1;
                        pend_tag_next     = TAG_OVF;
                        pend_text_next    = '0;
                        pend_parsed_next  = '0;
                        pend_limited_next = '0;
                        state_next        = ST_HOLD;
                    end
                end
            end
            ST_WALK:
            begin
                st_ctrl.shift = 1'b1;
                sc_ctrl.step  = 1'b1;
                walk_next     = walk_reg + 1'b1;
                if (walk_reg == WALK_LAST)
                begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                if (pend_tag_reg == TAG_VEL)
                begin
                    pend_parsed_next  = signed_val;
                    pend_limited_next = (!sc_res.neg && (sc_res.mag > limit_ext)) ?
                                        limit_ext : signed_val;
                end
                else
                begin
                    pend_parsed_next  = '0;
                    pend_limited_next = '0;
                end
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || field.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_tag_next     = pend_tag_reg;
                    out_text_next    = pend_text_reg;
                    out_parsed_next  = pend_parsed_reg;
                    out_limited_next = pend_limited_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pend_tag_reg     <= pend_tag_next;
        pend_text_reg    <= pend_text_next;
        pend_parsed_reg  <= pend_parsed_next;
        pend_limited_reg <= pend_limited_next;
        out_tag_reg      <= out_tag_next;
        out_text_reg     <= out_text_next;
        out_parsed_reg   <= out_parsed_next;
        out_limited_reg  <= out_limited_next;
    end

    assign field.valid         = out_valid_reg;
    assign field.field_tag     = out_tag_reg;
    assign field.field_text    = out_text_reg;
    assign field.parsed_value  = out_parsed_reg;
    assign field.limited_value = out_limited_reg;

    // walk ends right after the last stored character
    `ASSERT_NEXT(a_walk_to_limit, clk, rst_n, state_reg == ST_WALK && walk_reg == WALK_LAST, state_reg == ST_LIMIT, "character walk did not end on time")

    // the walk leaves the store empty
    `ASSERT_IMPL(a_store_drained, clk, rst_n, state_reg == ST_LIMIT, !store_full && store_head == '0, "store not empty after walk")

    // overflow items carry nothing
    `ASSERT_IMPL(a_ovf_empty, clk, rst_n, field.valid && field.field_tag == TAG_OVF, field.field_text == '0 && field.parsed_value == '0, "overflow item with payload")

    // only velocity items carry values
    `ASSERT_IMPL(a_values_vel_only, clk, rst_n, field.valid && field.field_tag != TAG_VEL, field.parsed_value == '0 && field.limited_value == '0, "value on non-velocity item")

endmodule
